// ===== src/ebps_pkg.sv =====
// ----------------------------------------------------------------------------
// ebps_pkg
// Shared types and codes for the encoder and button press scanner.
// ----------------------------------------------------------------------------
package ebps_pkg;

    localparam int BTN_W      = 5;
    localparam int POS_W      = 3;
    localparam int HOLD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CLICK_W    = 8;

    localparam logic [BTN_W-1:0] BTN_ALL = 5'h1F;

    // item kinds
    localparam logic [1:0] FUNC_SCAN  = 2'd0;
    localparam logic [1:0] FUNC_TAKE  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER  = 3'd6;

    // press codes, also the priority order
    localparam logic [POS_W-1:0] PRESS_UP     = 3'd0;
    localparam logic [POS_W-1:0] PRESS_DOWN   = 3'd1;
    localparam logic [POS_W-1:0] PRESS_RIGHT  = 3'd2;
    localparam logic [POS_W-1:0] PRESS_LEFT   = 3'd3;
    localparam logic [POS_W-1:0] PRESS_CENTER = 3'd4;

    typedef struct packed {
        logic [1:0]       func;
        logic             enc_a_low;
        logic             enc_b_low;
        logic [BTN_W-1:0] button_bits;
        logic             read_error;
    } t_in_item;

    typedef struct packed {
        logic             press_valid;
        logic [POS_W-1:0] press_code;
        logic             pending_after;
    } t_out_item;

    typedef struct packed {
        logic [HOLD_W-1:0] holdoff_ticks;
        logic              encoder_enable;
        logic [POS_W-1:0]  up_bit;
        logic [POS_W-1:0]  down_bit;
        logic [POS_W-1:0]  right_bit;
        logic [POS_W-1:0]  left_bit;
        logic [POS_W-1:0]  center_bit;
    } t_cfg;

endpackage

// ===== src/ebps_cfg.sv =====
// ----------------------------------------------------------------------------
// ebps_cfg
// Configuration register file, write-only, one register per index.
// ----------------------------------------------------------------------------
module ebps_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ebps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ebps_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output ebps_pkg::t_cfg                     o_cfg
);
    import ebps_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.holdoff_ticks  <= '0;
            r_cfg.encoder_enable <= 1'b1;
            r_cfg.up_bit         <= PRESS_UP;
            r_cfg.down_bit       <= PRESS_DOWN;
            r_cfg.right_bit      <= PRESS_RIGHT;
            r_cfg.left_bit       <= PRESS_LEFT;
            r_cfg.center_bit     <= PRESS_CENTER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLDOFF: r_cfg.holdoff_ticks  <= i_cfg_wdata[HOLD_W-1:0];
                CFG_ENC_EN:  r_cfg.encoder_enable <= i_cfg_wdata[0];
                CFG_UP:      r_cfg.up_bit         <= i_cfg_wdata[POS_W-1:0];
                CFG_DOWN:    r_cfg.down_bit       <= i_cfg_wdata[POS_W-1:0];
                CFG_RIGHT:   r_cfg.right_bit      <= i_cfg_wdata[POS_W-1:0];
                CFG_LEFT:    r_cfg.left_bit       <= i_cfg_wdata[POS_W-1:0];
                CFG_CENTER:  r_cfg.center_bit     <= i_cfg_wdata[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/ebps_core.sv =====
// ----------------------------------------------------------------------------
// ebps_core
// Scanner state and the single-pass next-state / result logic per beat.
// ----------------------------------------------------------------------------
module ebps_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  ebps_pkg::t_in_item    i_item,
    input  ebps_pkg::t_cfg        i_cfg,
    output ebps_pkg::t_out_item   o_result
);
    import ebps_pkg::*;

    // one-hot mask for a bit position; positions above four never match
    function automatic logic [BTN_W-1:0] pos_mask(input logic [POS_W-1:0] pos);
        logic [BTN_W-1:0] m;
        m = '0;
        if (pos < POS_W'(BTN_W))
            m[pos] = 1'b1;
        return m;
    endfunction

    logic [BTN_W-1:0]   r_prev_buttons,  n_prev_buttons;
    logic               r_pending,       n_pending;
    logic [POS_W-1:0]   r_code_held,     n_code_held;
    logic signed [1:0]  r_enc_dir,       n_enc_dir;
    logic               r_enc_turning,   n_enc_turning;
    logic signed [CLICK_W-1:0] r_clicks, n_clicks;
    logic [HOLD_W-1:0]  r_holdoff,       n_holdoff;

    always_comb begin
        logic [BTN_W-1:0]        nb;
        logic [BTN_W-1:0]        diff;
        logic [BTN_W-1:0]        m;
        logic [BTN_W-1:0]        masks [BTN_W];
        logic signed [CLICK_W:0] sum;
        logic                    found;
        logic                    a;
        logic                    b;

        n_prev_buttons = r_prev_buttons;
        n_pending      = r_pending;
        n_code_held    = r_code_held;
        n_enc_dir      = r_enc_dir;
        n_enc_turning  = r_enc_turning;
        n_clicks       = r_clicks;
        n_holdoff      = r_holdoff;
        o_result       = '0;

        masks[0] = pos_mask(i_cfg.up_bit);
        masks[1] = pos_mask(i_cfg.down_bit);
        masks[2] = pos_mask(i_cfg.right_bit);
        masks[3] = pos_mask(i_cfg.left_bit);
        masks[4] = pos_mask(i_cfg.center_bit);

        a     = i_item.enc_a_low;
        b     = i_item.enc_b_low;
        sum   = '0;
        found = 1'b0;
        nb    = '0;
        diff  = '0;
        m     = '0;

        case (i_item.func)
            FUNC_SCAN: begin
                if (!r_pending && r_holdoff == '0) begin
                    // encoder: a detent is both pins reading low, half-way is both high
                    if (i_cfg.encoder_enable) begin
                        if (a && b) begin
                            if (r_enc_turning) begin
                                sum = $signed({r_clicks[CLICK_W-1], r_clicks})
                                    + $signed({{(CLICK_W-1){r_enc_dir[1]}}, r_enc_dir});
                                if (sum > (CLICK_W+1)'(127))
                                    n_clicks = CLICK_W'(127);
                                else if (sum < -(CLICK_W+1)'(127))
                                    n_clicks = -CLICK_W'(127);
                                else
                                    n_clicks = sum[CLICK_W-1:0];
                                n_enc_turning = 1'b0;
                            end
                            n_enc_dir = 2'sd0;
                        end else if (!a && !b) begin
                            n_enc_turning = 1'b1;
                        end else if (!r_enc_turning) begin
                            n_enc_dir = a ? 2'sd1 : -2'sd1;
                        end
                    end

                    if (!i_item.read_error) begin
                        nb = i_item.button_bits;
                        // fold clicks in: positive acts as down, negative as up
                        if (i_cfg.encoder_enable && n_clicks != '0) begin
                            nb       = nb & ~(n_clicks > 0 ? masks[1] : masks[0]);
                            n_clicks = '0;
                        end
                        diff           = nb ^ r_prev_buttons;
                        n_prev_buttons = nb;
                        for (int i = 0; i < BTN_W; i++) begin
                            m = masks[i];
                            if (!found && (diff & m) != '0 && (nb & m) == '0) begin
                                found       = 1'b1;
                                n_code_held = POS_W'(i);
                            end
                        end
                        if (found) begin
                            n_pending            = 1'b1;
                            n_holdoff            = i_cfg.holdoff_ticks;
                            o_result.press_valid = 1'b1;
                            o_result.press_code  = n_code_held;
                        end
                    end
                end
            end
            FUNC_TAKE: begin
                if (r_pending) begin
                    o_result.press_valid = 1'b1;
                    o_result.press_code  = r_code_held;
                end
                n_pending = 1'b0;
            end
            FUNC_CLEAR: begin
                n_prev_buttons = BTN_ALL;
            end
            FUNC_TICK: begin
                if (r_holdoff != '0)
                    n_holdoff = r_holdoff - HOLD_W'(1);
            end
            default: begin
            end
        endcase

        o_result.pending_after = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= BTN_ALL;
            r_pending      <= 1'b0;
            r_code_held    <= '0;
            r_enc_dir      <= 2'sd0;
            r_enc_turning  <= 1'b0;
            r_clicks       <= '0;
            r_holdoff      <= '0;
        end else if (i_fire) begin
            r_prev_buttons <= n_prev_buttons;
            r_pending      <= n_pending;
            r_code_held    <= n_code_held;
            r_enc_dir      <= n_enc_dir;
            r_enc_turning  <= n_enc_turning;
            r_clicks       <= n_clicks;
            r_holdoff      <= n_holdoff;
        end
    end

endmodule

// ===== src/encoder_button_press_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_button_press_scanner_unit
// Rotary encoder tracking and button press latching, one result per beat.
// ----------------------------------------------------------------------------
//
//   channel   signals                               dir  notes
//   --------  ------------------------------------  ---  -------------------
//   input     i_in_valid / o_in_ready / i_in_data    in   one item per beat
//   output    o_out_valid / i_out_ready / o_out_data out  one result per item
//   config    i_cfg_we / i_cfg_idx / i_cfg_wdata     in   write only, no wait
//
// Flow: one item per clock sustained while results are taken. A beat lands
// in the input register, is processed by the core's single-pass logic
// (state updates then) once the output register is free, and the result
// sits in the output register until it is taken.
// Reset: synchronous, active low; clears control and scanner state and loads
// the configuration defaults.
// Stalls: a held output register stops processing, the input register then
// fills and o_in_ready drops; ready recovers in the cycle the result is taken.
//
module encoder_button_press_scanner_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ebps_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ebps_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [ebps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ebps_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import ebps_pkg::*;

    t_cfg      cfg;
    t_out_item core_result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      proc_fire;

    // the item in the input register moves on when the result slot frees up
    assign proc_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_fire;

    ebps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ebps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc_fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out_item <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for encoder_button_press_scanner_unit: a directed
// opener, then randomized phases under several register settings and
// handshake idling patterns, checked beat by beat against an in-bench
// scanner model.
// ----------------------------------------------------------------------------

import ebps_pkg::*;

class press_scoreboard;

    localparam int CLICK_LIMIT = 127;

    t_out_item   press_expect_q[$];
    int unsigned fail_count;

    // register copies
    logic [HOLD_W-1:0] hold_ticks;
    logic              enc_on;
    logic [POS_W-1:0]  btn_pos [BTN_W];

    // scanner state
    logic [BTN_W-1:0]  last_buttons;
    logic              pend;
    logic [POS_W-1:0]  held_code;
    int                enc_dir;
    logic              enc_turn;
    int                clicks;
    logic [HOLD_W-1:0] hold_cnt;

    function new();
        hold_ticks = '0;
        enc_on = 1'b1;
        foreach (btn_pos[i]) btn_pos[i] = POS_W'(i);
        last_buttons = BTN_ALL;
        pend = 1'b0;
        held_code = '0;
        enc_dir = 0;
        enc_turn = 1'b0;
        clicks = 0;
        hold_cnt = '0;
        fail_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_HOLDOFF: hold_ticks = val;
            CFG_ENC_EN:  enc_on = val[0];
            CFG_UP:      btn_pos[PRESS_UP] = val[POS_W-1:0];
            CFG_DOWN:    btn_pos[PRESS_DOWN] = val[POS_W-1:0];
            CFG_RIGHT:   btn_pos[PRESS_RIGHT] = val[POS_W-1:0];
            CFG_LEFT:    btn_pos[PRESS_LEFT] = val[POS_W-1:0];
            CFG_CENTER:  btn_pos[PRESS_CENTER] = val[POS_W-1:0];
            default: ;
        endcase
    endfunction

    // a position above the top bit maps to no button at all
    function logic [BTN_W-1:0] button_mask(logic [POS_W-1:0] code);
        logic [POS_W-1:0] p;
        p = btn_pos[code];
        if (p >= BTN_W) return '0;
        return BTN_W'(1) << p;
    endfunction

    function void follow_encoder(logic a, logic b);
        int c;
        if (a && b) begin
            // detent: a finished turn adds one click in the direction seen, none if no direction was seen
            if (enc_turn) begin
                c = clicks + enc_dir;
                if (c > CLICK_LIMIT) c = CLICK_LIMIT;
                if (c < -CLICK_LIMIT) c = -CLICK_LIMIT;
                clicks = c;
                enc_turn = 1'b0;
            end
            enc_dir = 0;
        end else if (!a && !b) begin
            enc_turn = 1'b1;
        end else if (!enc_turn) begin
            enc_dir = a ? 1 : -1;
        end
    endfunction

    function logic scan_latches(t_in_item it);
        logic [BTN_W-1:0] nb;
        logic [BTN_W-1:0] diff;
        logic [BTN_W-1:0] m;
        if (pend || hold_cnt != '0) return 1'b0;
        if (enc_on) follow_encoder(it.enc_a_low, it.enc_b_low);
        if (it.read_error) return 1'b0;
        nb = it.button_bits;
        if (enc_on && clicks != 0) begin
            nb &= ~button_mask(clicks > 0 ? PRESS_DOWN : PRESS_UP);
            clicks = 0;
        end
        diff = nb ^ last_buttons;
        last_buttons = nb;
        for (int i = 0; i < BTN_W; i++) begin
            m = button_mask(POS_W'(i));
            if ((diff & m) != '0 && (nb & m) == '0) begin
                held_code = POS_W'(i);
                pend = 1'b1;
                hold_cnt = hold_ticks;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void note_item(t_in_item it);
        t_out_item want;
        want = '0;
        case (it.func)
            FUNC_SCAN: begin
                if (scan_latches(it)) begin
                    want.press_valid = 1'b1;
                    want.press_code = held_code;
                end
            end
            FUNC_TAKE: begin
                if (pend) begin
                    want.press_valid = 1'b1;
                    want.press_code = held_code;
                end
                pend = 1'b0;
            end
            FUNC_CLEAR: last_buttons = BTN_ALL;
            FUNC_TICK: begin
                if (hold_cnt != '0) hold_cnt = hold_cnt - 1'b1;
            end
            default: ;
        endcase
        want.pending_after = pend;
        press_expect_q.push_back(want);
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (press_expect_q.size() == 0) begin
            $display("%0t: unexpected result: valid %0b code %0d pending %0b",
                     $time, got.press_valid, got.press_code, got.pending_after);
            fail_count++;
            return;
        end
        want = press_expect_q.pop_front();
        if (got !== want) begin
            $display("%0t: mismatch: expected valid %0b code %0d pending %0b, got valid %0b code %0d pending %0b",
                     $time, want.press_valid, want.press_code, want.pending_after,
                     got.press_valid, got.press_code, got.pending_after);
            fail_count++;
        end
    endfunction

endclass

module testbench;

    localparam int IN_W        = $bits(t_in_item);
    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    press_scoreboard press_sb;

    // handshake idling, in percent, per phase
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int cycle_count = 0;

    // stimulus walk state: quadrature position 0..3 (0 is the detent),
    // preferred turning direction and the buttons currently held
    int               enc_pos = 0;
    int               enc_pref = 1;
    logic [BTN_W-1:0] held_buttons = BTN_ALL;

    encoder_button_press_scanner_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: ready is redrawn at every falling edge, so stalls land on
    // any cycle of the block's pipeline.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Every result beat is checked at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) press_sb.check_result(o_out_data);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("encoder_button_press_scanner_unit test failed");
            $finish;
        end
    end

    function automatic t_in_item beat_of(logic [1:0] f, logic a, logic b,
                                         logic [BTN_W-1:0] btn, logic err);
        t_in_item it;
        it.func = f;
        it.enc_a_low = a;
        it.enc_b_low = b;
        it.button_bits = btn;
        it.read_error = err;
        return it;
    endfunction

    // Pin levels for a quadrature position: 0 both low (detent), 1 A only,
    // 2 neither, 3 B only.
    function automatic logic pin_a(int pos);
        return pos < 2;
    endfunction

    function automatic logic pin_b(int pos);
        return pos == 0 || pos == 3;
    endfunction

    // Called at a falling edge, returns at the falling edge after the accept.
    // Valid is assigned once per falling edge: either the next beat or low.
    task automatic send_beat(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        press_sb.note_item(it);
        @(negedge i_clk);
    endtask

    // Lower valid and wait for every expected result, then let the input and
    // result registers settle so a register write meets an idle block.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (press_sb.press_expect_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        press_sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Mostly scans that follow a plausible knob walk and button activity,
    // with takes to release pending presses and ticks to run down holdoff.
    // Jumps in the walk give broken quadrature sequences.
    task automatic next_random_beat(output t_in_item it);
        int r;
        int s;
        logic [IN_W-1:0] noise;
        r = $urandom_range(99);
        noise = IN_W'($urandom);
        if (r < 55) begin
            s = $urandom_range(99);
            if (s >= 92) enc_pos = $urandom_range(3);
            else if (s >= 80) enc_pos = (enc_pos - enc_pref) & 3;
            else if (s >= 45) enc_pos = (enc_pos + enc_pref) & 3;
            if ($urandom_range(99) < 3) enc_pref = -enc_pref;
            if ($urandom_range(99) < 25) begin
                s = $urandom_range(9);
                if (s < 4) held_buttons = BTN_ALL;
                else if (s < 8) held_buttons = BTN_ALL & ~(BTN_W'(1) << $urandom_range(4));
                else held_buttons = BTN_W'($urandom);
            end
            it = beat_of(FUNC_SCAN, pin_a(enc_pos), pin_b(enc_pos), held_buttons,
                         $urandom_range(99) < 12);
        end else begin
            // the other kinds ignore the pin and button fields; fill with noise
            it = t_in_item'(noise);
            if (r < 70) it.func = FUNC_TAKE;
            else if (r < 77) it.func = FUNC_CLEAR;
            else it.func = FUNC_TICK;
        end
    endtask

    // Steady turning with every read failing, so the click count runs into
    // saturation; the last scan reads cleanly and folds the clicks in.
    task automatic spin_encoder(input int dir, input int n_scans);
        send_beat(beat_of(FUNC_TAKE, 1'b0, 1'b0, BTN_ALL, 1'b0));
        repeat (15) send_beat(beat_of(FUNC_TICK, 1'b0, 1'b0, BTN_ALL, 1'b0));
        enc_pos = 0;
        for (int k = 0; k < n_scans; k++) begin
            send_beat(beat_of(FUNC_SCAN, pin_a(enc_pos), pin_b(enc_pos),
                              BTN_W'($urandom), k != n_scans - 1));
            enc_pos = (enc_pos + dir) & 3;
        end
    endtask

    task automatic run_phase(input t_cfg cfg, input int send_pct, input int stall_pct,
                             input int n_items, input int spin_dir);
        t_in_item it;
        write_reg(CFG_HOLDOFF, cfg.holdoff_ticks);
        write_reg(CFG_ENC_EN, CFG_DATA_W'(cfg.encoder_enable));
        write_reg(CFG_UP, CFG_DATA_W'(cfg.up_bit));
        write_reg(CFG_DOWN, CFG_DATA_W'(cfg.down_bit));
        write_reg(CFG_RIGHT, CFG_DATA_W'(cfg.right_bit));
        write_reg(CFG_LEFT, CFG_DATA_W'(cfg.left_bit));
        write_reg(CFG_CENTER, CFG_DATA_W'(cfg.center_bit));
        i_cfg_we <= 1'b0;
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
        if (spin_dir != 0) begin
            spin_encoder(spin_dir, n_items);
        end else begin
            repeat (n_items) begin
                next_random_beat(it);
                send_beat(it);
            end
        end
        drain_results();
    endtask

    t_cfg rand_cfg;

    initial begin
        press_sb = new();

        // reset held, then released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opener on the reset register values, no idling.
        // Take and tick with nothing going on.
        send_beat(beat_of(FUNC_TAKE, 1'b1, 1'b1, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b1, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_CLEAR, 1'b1, 1'b1, BTN_ALL, 1'b0));
        // up press, then a scan ignored while it is pending, then take it
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, 5'h1E, 1'b0));
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, 5'h00, 1'b0));
        send_beat(beat_of(FUNC_TAKE, 1'b1, 1'b1, 5'h00, 1'b0));
        // failed read changes nothing; then all fall, down wins over the rest
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, 5'h00, 1'b1));
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, 5'h00, 1'b0));
        send_beat(beat_of(FUNC_TAKE, 1'b1, 1'b1, 5'h00, 1'b0));
        // one clockwise detent, completed during a failed read, folds to down
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b0, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_SCAN, 1'b0, 1'b0, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, BTN_ALL, 1'b1));
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_TAKE, 1'b1, 1'b1, BTN_ALL, 1'b0));
        // one counter-clockwise detent folds to up
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_SCAN, 1'b0, 1'b1, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_SCAN, 1'b0, 1'b0, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_TAKE, 1'b1, 1'b1, BTN_ALL, 1'b0));
        // history cleared, center alone falls
        send_beat(beat_of(FUNC_CLEAR, 1'b1, 1'b1, BTN_ALL, 1'b0));
        send_beat(beat_of(FUNC_SCAN, 1'b1, 1'b1, 5'h0F, 1'b0));
        send_beat(beat_of(FUNC_TAKE, 1'b1, 1'b1, 5'h0F, 1'b0));
        send_beat(beat_of(FUNC_TICK, 1'b1, 1'b1, 5'h0F, 1'b0));
        drain_results();

        // Random phases. Holdoff stays small until the last phase, since a
        // press under the all-ones holdoff blocks scans for the rest of the run.
        run_phase('{32'd0, 1'b1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, 0, 0, 150, 0);
        run_phase('{32'd3, 1'b1, 3'd4, 3'd2, 3'd0, 3'd1, 3'd3}, 50, 0, 150, 0);
        // encoder off; shared positions and one position out of range
        run_phase('{32'd1, 1'b0, 3'd4, 3'd4, 3'd0, 3'd7, 3'd2}, 0, 50, 150, 0);
        // clockwise spin into positive saturation
        run_phase('{32'd0, 1'b1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, 28, 28, 520, 1);

        rand_cfg.holdoff_ticks = HOLD_W'($urandom_range(12));
        rand_cfg.encoder_enable = 1'b1;
        rand_cfg.up_bit = POS_W'($urandom_range(7));
        rand_cfg.down_bit = POS_W'($urandom_range(7));
        rand_cfg.right_bit = POS_W'($urandom_range(7));
        rand_cfg.left_bit = POS_W'($urandom_range(7));
        rand_cfg.center_bit = POS_W'($urandom_range(7));
        run_phase(rand_cfg, 0, 0, 120, 0);

        // up unreachable and down out of range: synthetic presses land nowhere
        run_phase('{32'd2, 1'b1, 3'd7, 3'd5, 3'd1, 3'd0, 3'd3}, 28, 28, 100, 0);
        // counter-clockwise spin into negative saturation
        run_phase('{32'd0, 1'b1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, 50, 0, 520, -1);

        rand_cfg.holdoff_ticks = HOLD_W'($urandom_range(12));
        rand_cfg.encoder_enable = 1'($urandom);
        rand_cfg.up_bit = POS_W'($urandom_range(4));
        rand_cfg.down_bit = POS_W'($urandom_range(4));
        rand_cfg.right_bit = POS_W'($urandom_range(4));
        rand_cfg.left_bit = POS_W'($urandom_range(4));
        rand_cfg.center_bit = POS_W'($urandom_range(4));
        run_phase(rand_cfg, 0, 50, 100, 0);

        // largest holdoff last
        run_phase('{32'hFFFF_FFFF, 1'b1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, 28, 28, 50, 0);

        if (press_sb.fail_count == 0 && press_sb.press_expect_q.size() == 0) begin
            $display("encoder_button_press_scanner_unit test passed");
        end else begin
            $display("encoder_button_press_scanner_unit test failed");
        end
        $finish;
    end

endmodule
